// ----- rtl/v3an_pkg.sv -----
// v3an_pkg: shared types and operation codes for the vector3 alu/normalize block
// no dependencies; imported by v3an_op and vector3_alu_normalize
`timescale 1ns / 1ps
`default_nettype none

package v3an_pkg;

    typedef logic [1:0] action_t;

    localparam action_t ACT_ADD   = 2'd0;
    localparam action_t ACT_SUB   = 2'd1;
    localparam action_t ACT_CROSS = 2'd2;
    localparam action_t ACT_DOT   = 2'd3;

    // control bits that travel beside the data of each pipeline stage
    typedef struct packed {
        logic valid;
        logic norm;
        logic sat;
    } v3an_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/v3an_op.sv -----
// v3an_op: three-stage operation pipeline (add, sub, cross, dot) with round and clamp
// depends on v3an_pkg
`timescale 1ns / 1ps
`default_nettype none

module v3an_op #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire v3an_pkg::v3an_ctl_t   in_ctl,
    input  wire v3an_pkg::action_t     action,
    input  wire logic signed [CW-1:0]  a_x,
    input  wire logic signed [CW-1:0]  a_y,
    input  wire logic signed [CW-1:0]  a_z,
    input  wire logic signed [CW-1:0]  b_x,
    input  wire logic signed [CW-1:0]  b_y,
    input  wire logic signed [CW-1:0]  b_z,
    output v3an_pkg::v3an_ctl_t        out_ctl,
    output logic signed [CW-1:0]       r_x,
    output logic signed [CW-1:0]       r_y,
    output logic signed [CW-1:0]       r_z
);
    import v3an_pkg::*;

    localparam int PW = 2 * CW;
    localparam int SW = 2 * CW + 2;
    localparam int RW = SW - FB;
    localparam int AW = CW + 1;
    localparam logic signed [SW-1:0] HALF = {{(SW - FB){1'b0}}, 1'b1, {(FB - 1){1'b0}}};

    // stage 1: products and plain sums
    logic signed [CW-1:0] ma [6];
    logic signed [CW-1:0] mb [6];
    logic signed [PW-1:0] p_reg [6];
    logic signed [PW-1:0] p_next [6];
    logic signed [AW-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [AW-1:0] s1_x_next, s1_y_next, s1_z_next;
    action_t              act1_reg;
    v3an_ctl_t            ctl1_reg;

    // stage 2: exact wide sums with rounding offset
    logic signed [SW-1:0] w_x_reg, w_y_reg, w_z_reg;
    logic signed [SW-1:0] w_x_next, w_y_next, w_z_next;
    logic signed [AW-1:0] s2_x_reg, s2_y_reg, s2_z_reg;
    action_t              act2_reg;
    v3an_ctl_t            ctl2_reg;

    // stage 3: select and clamp
    logic signed [RW-1:0] pre_x, pre_y, pre_z;
    logic [CW:0]          c_x, c_y, c_z;
    logic signed [CW-1:0] r_x_reg, r_y_reg, r_z_reg;
    logic signed [CW-1:0] r_x_next, r_y_next, r_z_next;
    v3an_ctl_t            ctl3_reg;
    logic                 sat_next;

    function automatic logic [CW:0] sat_fn(input logic signed [RW-1:0] v);
        logic [RW-CW:0] hi;
        hi = v[RW-1:CW-1];
        if (&hi || ~|hi)
            return {1'b0, v[CW-1:0]};
        else if (v[RW-1])
            return {1'b1, 1'b1, {(CW - 1){1'b0}}};
        else
            return {1'b1, 1'b0, {(CW - 1){1'b1}}};
    endfunction

    always_comb
    begin
        // cross product pairs; dot reuses the even multipliers
        ma[0] = a_y; mb[0] = b_z;
        ma[1] = a_z; mb[1] = b_y;
        ma[2] = a_z; mb[2] = b_x;
        ma[3] = a_x; mb[3] = b_z;
        ma[4] = a_x; mb[4] = b_y;
        ma[5] = a_y; mb[5] = b_x;
        if (action == ACT_DOT)
        begin
            ma[0] = a_x; mb[0] = b_x;
            ma[2] = a_y; mb[2] = b_y;
            ma[4] = a_z; mb[4] = b_z;
        end
        for (int i = 0; i < 6; i++)
        begin
            p_next[i] = PW'(ma[i]) * PW'(mb[i]);
        end
        if (action == ACT_SUB)
        begin
            s1_x_next = AW'(a_x) - AW'(b_x);
            s1_y_next = AW'(a_y) - AW'(b_y);
            s1_z_next = AW'(a_z) - AW'(b_z);
        end
        else
        begin
            s1_x_next = AW'(a_x) + AW'(b_x);
            s1_y_next = AW'(a_y) + AW'(b_y);
            s1_z_next = AW'(a_z) + AW'(b_z);
        end
    end

    always_comb
    begin
        if (act1_reg == ACT_DOT)
            w_x_next = SW'(p_reg[0]) + SW'(p_reg[2]) + SW'(p_reg[4]) + HALF;
        else
            w_x_next = SW'(p_reg[0]) - SW'(p_reg[1]) + HALF;
        w_y_next = SW'(p_reg[2]) - SW'(p_reg[3]) + HALF;
        w_z_next = SW'(p_reg[4]) - SW'(p_reg[5]) + HALF;
    end

    always_comb
    begin
        case (act2_reg)
            ACT_ADD, ACT_SUB:
            begin
                pre_x = RW'(s2_x_reg);
                pre_y = RW'(s2_y_reg);
                pre_z = RW'(s2_z_reg);
            end
            ACT_CROSS:
            begin
                pre_x = w_x_reg[SW-1:FB];
                pre_y = w_y_reg[SW-1:FB];
                pre_z = w_z_reg[SW-1:FB];
            end
            default:
            begin
                // dot: one scalar copied to all components
                pre_x = w_x_reg[SW-1:FB];
                pre_y = w_x_reg[SW-1:FB];
                pre_z = w_x_reg[SW-1:FB];
            end
        endcase
        c_x = sat_fn(pre_x);
        c_y = sat_fn(pre_y);
        c_z = sat_fn(pre_z);
        r_x_next = c_x[CW-1:0];
        r_y_next = c_y[CW-1:0];
        r_z_next = c_z[CW-1:0];
        sat_next = c_x[CW] | c_y[CW] | c_z[CW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                p_reg[i] <= p_next[i];
            end
            s1_x_reg <= s1_x_next;
            s1_y_reg <= s1_y_next;
            s1_z_reg <= s1_z_next;
            w_x_reg  <= w_x_next;
            w_y_reg  <= w_y_next;
            w_z_reg  <= w_z_next;
            s2_x_reg <= s1_x_reg;
            s2_y_reg <= s1_y_reg;
            s2_z_reg <= s1_z_reg;
            r_x_reg  <= r_x_next;
            r_y_reg  <= r_y_next;
            r_z_reg  <= r_z_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act1_reg <= ACT_ADD;
            act2_reg <= ACT_ADD;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            act1_reg <= action;
            act2_reg <= act1_reg;
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= '{valid: ctl2_reg.valid, norm: ctl2_reg.norm, sat: sat_next};
        end
    end

    assign out_ctl = ctl3_reg;
    assign r_x     = r_x_reg;
    assign r_y     = r_y_reg;
    assign r_z     = r_z_reg;

endmodule

`default_nettype wire

// ----- rtl/v3an_unit.sv -----
// v3an_unit: pipelined restoring divide then digit-by-digit square root for one component
// gives floor(sqrt(m2 * 2^(2*FB+2) / s)); no package dependency
`timescale 1ns / 1ps
`default_nettype none

module v3an_unit #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [2*CW-1:0]      m2,
    input  wire logic [2*CW-1:0]      s,
    output logic [FB+1:0]             y
);
    localparam int PW  = 2 * CW;
    localparam int QW  = 2 * FB + 3;
    localparam int YW  = FB + 2;
    localparam int RMW = YW + 2;

    logic [PW-1:0]  d_rem_reg [QW];
    logic [PW-1:0]  d_s_reg   [QW];
    logic [QW-1:0]  d_q_reg   [QW];

    logic [RMW-1:0]  t_rem_reg  [YW];
    logic [YW-1:0]   t_root_reg [YW];
    logic [2*YW-1:0] t_rest_reg [YW];

    genvar k;

    // one quotient bit per stage
    for (k = 0; k < QW; k++)
    begin : g_div
        logic [PW-1:0] rem_in, s_in;
        logic [QW-1:0] q_in;
        logic [PW:0]   trial;
        logic [PW-1:0] d_rem_next;
        logic [QW-1:0] d_q_next;

        if (k == 0)
        begin : g_first
            assign rem_in = {1'b0, m2[PW-1:1]};
            assign q_in   = {m2[0], {(QW - 1){1'b0}}};
            assign s_in   = s;
        end
        else
        begin : g_rest
            assign rem_in = d_rem_reg[k-1];
            assign q_in   = d_q_reg[k-1];
            assign s_in   = d_s_reg[k-1];
        end

        assign trial = {rem_in, q_in[QW-1]};

        always_comb
        begin
            if (trial >= {1'b0, s_in})
            begin
                d_rem_next = PW'(trial - {1'b0, s_in});
                d_q_next   = {q_in[QW-2:0], 1'b1};
            end
            else
            begin
                d_rem_next = trial[PW-1:0];
                d_q_next   = {q_in[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_rem_reg[k] <= d_rem_next;
                d_q_reg[k]   <= d_q_next;
                d_s_reg[k]   <= s_in;
            end
        end
    end

    // one root bit per stage
    for (k = 0; k < YW; k++)
    begin : g_sqrt
        logic [RMW-1:0]  rem_in;
        logic [YW-1:0]   root_in;
        logic [2*YW-1:0] rest_in;
        logic [RMW+1:0]  rem2, tr;
        logic [RMW-1:0]  t_rem_next;
        logic [YW-1:0]   t_root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rest_in = {1'b0, d_q_reg[QW-1]};
        end
        else
        begin : g_rest
            assign rem_in  = t_rem_reg[k-1];
            assign root_in = t_root_reg[k-1];
            assign rest_in = t_rest_reg[k-1];
        end

        assign rem2 = {rem_in, rest_in[2*YW-1 -: 2]};
        assign tr   = {2'b00, root_in, 2'b01};

        always_comb
        begin
            if (rem2 >= tr)
            begin
                t_rem_next  = RMW'(rem2 - tr);
                t_root_next = {root_in[YW-2:0], 1'b1};
            end
            else
            begin
                t_rem_next  = rem2[RMW-1:0];
                t_root_next = {root_in[YW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_rem_reg[k]  <= t_rem_next;
                t_root_reg[k] <= t_root_next;
                t_rest_reg[k] <= {rest_in[2*YW-3:0], 2'b00};
            end
        end
    end

    assign y = t_root_reg[YW-1];

endmodule

`default_nettype wire

// ----- rtl/vector3_alu_normalize.sv -----
// vector3_alu_normalize: top level of the fixed-point vector alu with unit-length scaling
// depends on v3an_pkg, v3an_op, v3an_unit
`timescale 1ns / 1ps
`default_nettype none

// usage
//   s_axis carries one item per handshake: two 3-component signed fixed-point
//   vectors in tdata and the operation select plus normalize flag in tuser.
//   m_axis returns one item per input item, in order: the 3-component result
//   in tdata and the clamp flag in tuser.
// latency and throughput
//   one item per cycle sustained while m_axis_tready is high. items pass the
//   operation stages, the squares and magnitude sum registers, (2*FRAC_BITS+3)
//   divide stages, (FRAC_BITS+2) root stages and an output register. the depth
//   is set by the restoring divide and square root, one result bit per stage.
// reset
//   rst_n clears every valid bit, also those of the output/skid registers; data
//   paths and output/skid data are not reset. items in flight are dropped.
// stall
//   when m_axis_tready is low the output register holds; one more item may
//   land in the skid register, after which s_axis_tready drops and the whole
//   pipeline freezes until the skid register drains. s_axis_tready is a flop.
module vector3_alu_normalize #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z from the lowest bit up, zero padded to bytes
    input  wire logic [((6*COMP_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
    // action[1:0], normalize_result[2]
    input  wire logic [2:0]                                 s_axis_tuser,
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    // res_x, res_y, res_z from the lowest bit up, zero padded to bytes
    output logic [((3*COMP_WIDTH+7)/8)*8-1:0]               m_axis_tdata,
    // saturated
    output logic                                            m_axis_tuser
);
    import v3an_pkg::*;

    localparam int CW     = COMP_WIDTH;
    localparam int FB     = FRAC_BITS;
    localparam int PW     = 2 * CW;
    localparam int QW     = 2 * FB + 3;
    localparam int YW     = FB + 2;
    localparam int LAT    = QW + YW;
    localparam int OUT_DW = ((3 * CW + 7) / 8) * 8;

    logic skid_valid_reg;
    logic en;
    assign en            = ~skid_valid_reg;
    assign s_axis_tready = en;

    // operation pipeline
    v3an_ctl_t            in_ctl;
    v3an_ctl_t            op_ctl;
    logic signed [CW-1:0] op_r [3];

    assign in_ctl = '{valid: s_axis_tvalid, norm: s_axis_tuser[2], sat: 1'b0};

    v3an_op #(
        .CW (CW),
        .FB (FB)
    ) u_op (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (in_ctl),
        .action  (s_axis_tuser[1:0]),
        .a_x     (s_axis_tdata[0*CW +: CW]),
        .a_y     (s_axis_tdata[1*CW +: CW]),
        .a_z     (s_axis_tdata[2*CW +: CW]),
        .b_x     (s_axis_tdata[3*CW +: CW]),
        .b_y     (s_axis_tdata[4*CW +: CW]),
        .b_z     (s_axis_tdata[5*CW +: CW]),
        .out_ctl (op_ctl),
        .r_x     (op_r[0]),
        .r_y     (op_r[1]),
        .r_z     (op_r[2])
    );

    // squares of the clamped components
    logic [CW-1:0]        mag [3];
    logic [PW-1:0]        sq_next [3];
    logic [PW-1:0]        sq_reg [3];
    logic signed [CW-1:0] q_r_reg [3];
    v3an_ctl_t            q_ctl_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i]     = op_r[i][CW-1] ? CW'(-op_r[i]) : CW'(op_r[i]);
            sq_next[i] = PW'(mag[i]) * PW'(mag[i]);
        end
    end

    // sum of squares; three terms of at most 2^(2*CW-2) each never overflow PW bits
    logic [PW-1:0]        m2_reg [3];
    logic [PW-1:0]        ssum_reg;
    logic [PW-1:0]        ssum_next;
    logic signed [CW-1:0] a_r_reg [3];
    v3an_ctl_t            a_ctl_reg;

    assign ssum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]  <= sq_next[i];
                q_r_reg[i] <= op_r[i];
                m2_reg[i]  <= sq_reg[i];
                a_r_reg[i] <= q_r_reg[i];
            end
            ssum_reg <= ssum_next;
        end
    end

    // per-component divide and root
    logic [YW-1:0] y [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_unit
        v3an_unit #(
            .CW (CW),
            .FB (FB)
        ) u_unit (
            .clk (clk),
            .en  (en),
            .m2  (m2_reg[c]),
            .s   (ssum_reg),
            .y   (y[c])
        );
    end

    // delay line that keeps the operation result beside the root pipeline
    logic [3*CW-1:0] dl_r_reg   [LAT];
    v3an_ctl_t       dl_ctl_reg [LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_r_reg[0] <= {a_r_reg[2], a_r_reg[1], a_r_reg[0]};
            for (int k = 1; k < LAT; k++)
            begin
                dl_r_reg[k] <= dl_r_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_ctl_reg <= '0;
            a_ctl_reg <= '0;
            for (int k = 0; k < LAT; k++)
            begin
                dl_ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            q_ctl_reg     <= op_ctl;
            a_ctl_reg     <= q_ctl_reg;
            dl_ctl_reg[0] <= a_ctl_reg;
            for (int k = 1; k < LAT; k++)
            begin
                dl_ctl_reg[k] <= dl_ctl_reg[k-1];
            end
        end
    end

    // round the doubled root to nearest, ties away from zero, restore the sign
    v3an_ctl_t            t_ctl;
    logic signed [CW-1:0] t_r [3];
    logic [YW:0]          y_inc [3];
    logic [CW-1:0]        u_mag [3];
    logic signed [CW-1:0] res [3];
    logic [3*CW-1:0]      res_data;
    logic                 leave;

    assign t_ctl = dl_ctl_reg[LAT-1];
    assign leave = t_ctl.valid & en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_r[i]   = dl_r_reg[LAT-1][i*CW +: CW];
            y_inc[i] = {1'b0, y[i]} + (YW + 1)'(1);
            u_mag[i] = (t_r[i] == '0) ? '0 : CW'(y_inc[i][YW:1]);
            if (!t_ctl.norm)
                res[i] = t_r[i];
            else if (t_r[i][CW-1])
                res[i] = -$signed(u_mag[i]);
            else
                res[i] = $signed(u_mag[i]);
        end
    end

    assign res_data = {res[2], res[1], res[0]};

    // output register with one skid entry
    logic                out_valid_reg;
    logic [OUT_DW-1:0]   out_data_reg;
    logic                out_sat_reg;
    logic [OUT_DW-1:0]   skid_data_reg;
    logic                skid_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= leave;
            end
        end
        else if (leave)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_sat_reg  <= skid_sat_reg;
            end
            else
            begin
                out_data_reg <= OUT_DW'(res_data);
                out_sat_reg  <= t_ctl.sat;
            end
        end
        else if (leave)
        begin
            skid_data_reg <= OUT_DW'(res_data);
            skid_sat_reg  <= t_ctl.sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule

`default_nettype wire
